// ===== rtl/dnle_pkg.sv =====
// shared types, constants and helpers for the dns name label encoder
// no dependencies; used by every rtl file of the block
package dnle_pkg;

  localparam int PosW       = 16;
  localparam int LenW       = 7;
  localparam int QDepth     = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;
  localparam int SlotIdxW   = 2;

  localparam logic [LenW-1:0]     LabelMax   = 7'd127;
  localparam logic [LenW-1:0]     LabelLimit = 7'd64;
  localparam logic [7:0]          DotChar    = 8'h2E;
  localparam logic [7:0]          TermByte   = 8'h00;
  localparam logic [PosW-1:0]     BufReset   = 16'd512;
  localparam logic [SlotIdxW-1:0] SlotFirst  = 2'd0;
  localparam logic [SlotIdxW-1:0] SlotMid    = 2'd1;
  localparam logic [SlotIdxW-1:0] SlotLast   = 2'd2;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [PosW:0]   wide_t;

  typedef struct packed {
    logic       valid;
    pos_t       pos;
    logic [7:0] data;
  } slot_t;

  typedef struct packed {
    logic            three;
    logic            done;
    logic            failed;
    pos_t            off_mid;
    pos_t            off_last;
    slot_t [2:0]     slot;
  } bundle_t;

  function automatic pos_t sat_pos(input pos_t v);
    sat_pos = (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic slot_t mk_slot(input logic valid, input wide_t pos,
                                    input logic [7:0] data);
    slot_t s;
    s.valid = valid;
    s.pos   = valid ? pos[PosW-1:0] : '0;
    s.data  = valid ? data : '0;
    mk_slot = s;
  endfunction

endpackage

// ===== rtl/dnle_core.sv =====
// name state, buffer size register and per-character result computation
// depends on dnle_pkg
module dnle_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [15:0]      cfg_data,
  input  logic             accept,
  input  logic [7:0]       name_char,
  input  logic             final_char,
  input  logic             new_buffer,
  output dnle_pkg::bundle_t bundle
);

  logic [15:0]                   buffer_size;
  dnle_pkg::pos_t                write_offset;
  dnle_pkg::pos_t                label_start;
  logic [dnle_pkg::LenW-1:0]     label_length;
  dnle_pkg::pos_t                name_length;
  logic                          failed_flag;

  dnle_pkg::pos_t                base, ls, nl, nl_inc, offset_next;
  logic [dnle_pkg::LenW-1:0]     ll, ll_inc;
  logic                          ff, ff_dot, ff_lab, ff_fit, ff_end, is_dot;
  dnle_pkg::wide_t               bs, pos_label, pos_char, pos_term, need;

  always_comb begin
    base   = new_buffer ? '0 : write_offset;
    ls     = new_buffer ? '0 : label_start;
    ll     = new_buffer ? '0 : label_length;
    nl     = new_buffer ? '0 : name_length;
    ff     = new_buffer ? 1'b0 : failed_flag;
    is_dot = (name_char == dnle_pkg::DotChar);
    nl_inc = dnle_pkg::sat_pos(nl);
    ll_inc = (ll == dnle_pkg::LabelMax) ? ll : ll + 7'd1;
    bs        = {1'b0, buffer_size};
    pos_label = {1'b0, base} + {1'b0, ls};
    pos_char  = {1'b0, base} + {1'b0, nl} + 17'd1;
    pos_term  = {1'b0, base} + {1'b0, nl_inc} + 17'd1;
    need      = {1'b0, base} + {1'b0, nl_inc} + 17'd2;
    ff_dot = ff || (ll == '0) || (ll >= dnle_pkg::LabelLimit);
    ff_lab = ff || (ll_inc >= dnle_pkg::LabelLimit);
    // name plus two past the buffer end, compared at full width through pos_term
    ff_fit = ff_lab || (pos_term >= bs);

    if (is_dot) begin
      ff_end = final_char ? 1'b1 : ff_dot;
      bundle.slot[0] = dnle_pkg::mk_slot(!ff_dot && (pos_label < bs), pos_label,
                                         {1'b0, ll});
      bundle.slot[1] = dnle_pkg::mk_slot(1'b0, '0, '0);
      bundle.slot[2] = dnle_pkg::mk_slot(1'b0, '0, '0);
    end else begin
      ff_end = final_char ? ff_fit : ff;
      bundle.slot[0] = dnle_pkg::mk_slot(!ff && (pos_char < bs), pos_char, name_char);
      bundle.slot[1] = dnle_pkg::mk_slot(final_char && !ff_lab && (pos_label < bs),
                                         pos_label, {1'b0, ll_inc});
      bundle.slot[2] = dnle_pkg::mk_slot(final_char && !ff_fit && (pos_term < bs),
                                         pos_term, dnle_pkg::TermByte);
    end

    offset_next     = (final_char && !ff_end) ? need[dnle_pkg::PosW-1:0] : base;
    bundle.three    = final_char;
    bundle.done     = final_char;
    bundle.failed   = final_char && ff_end;
    bundle.off_mid  = base;
    bundle.off_last = offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size  <= dnle_pkg::BufReset;
      write_offset <= '0;
      label_start  <= '0;
      label_length <= '0;
      name_length  <= '0;
      failed_flag  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        buffer_size <= cfg_data;
      end
      if (accept) begin
        write_offset <= offset_next;
        if (final_char) begin
          label_start  <= '0;
          label_length <= '0;
          name_length  <= '0;
          failed_flag  <= 1'b0;
        end else if (is_dot) begin
          label_start  <= nl_inc;
          label_length <= '0;
          name_length  <= nl_inc;
          failed_flag  <= ff_dot;
        end else begin
          label_start  <= ls;
          label_length <= ll_inc;
          name_length  <= nl_inc;
          failed_flag  <= ff;
        end
      end
    end
  end

  // a failed name leaves the offset where the name started
  a_fail_keeps_offset: assert property (@(posedge clk) disable iff (rst)
    accept && bundle.failed |=> write_offset == $past(base))
    else $error("offset moved on failed name");

  // the terminator is never written for a failed name
  a_fail_no_term: assert property (@(posedge clk) disable iff (rst)
    accept && bundle.failed |-> !bundle.slot[2].valid)
    else $error("terminator written for failed name");

  // a successful name ends exactly two bytes past its last character
  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    accept && final_char && !bundle.failed |->
      bundle.off_last == need[dnle_pkg::PosW-1:0])
    else $error("bad offset after name");

endmodule

// ===== rtl/dnle_queue.sv =====
// small queue of result groups, one group per accepted character
// depends on dnle_pkg
module dnle_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dnle_pkg::bundle_t din,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output dnle_pkg::bundle_t head
);

  dnle_pkg::bundle_t              mem [dnle_pkg::QDepth];
  logic [dnle_pkg::QPtrW-1:0]     wr_ptr, rd_ptr;
  logic [dnle_pkg::QCntW-1:0]     count;

  assign full  = (count == dnle_pkg::QCntW'(dnle_pkg::QDepth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= dnle_pkg::QCntW'(dnle_pkg::QDepth))
    else $error("queue count out of range");

endmodule

// ===== rtl/dnle_out.sv =====
// steps through the slots of the head result group, one beat per slot
// depends on dnle_pkg
module dnle_out (
  input  logic              clk,
  input  logic              rst,
  input  dnle_pkg::bundle_t head,
  input  logic              empty,
  input  logic              result_ready,
  output logic              pop,
  output logic              result_valid,
  output logic              write_valid,
  output logic [15:0]       write_position,
  output logic [7:0]        write_byte,
  output logic              run_end,
  output logic              name_done,
  output logic              name_failed,
  output logic [15:0]       offset_after
);

  logic [dnle_pkg::SlotIdxW-1:0] idx;
  logic                          last;
  dnle_pkg::slot_t               sel;

  always_comb begin
    case (idx)
      dnle_pkg::SlotFirst: sel = head.slot[0];
      dnle_pkg::SlotMid:   sel = head.slot[1];
      dnle_pkg::SlotLast:  sel = head.slot[2];
      default:             sel = head.slot[0];
    endcase
  end

  assign last           = head.three ? (idx == dnle_pkg::SlotLast) : 1'b1;
  assign result_valid   = !empty;
  assign pop            = !empty && result_ready && last;
  assign write_valid    = sel.valid;
  assign write_position = sel.pos;
  assign write_byte     = sel.data;
  assign run_end        = last;
  assign name_done      = head.done && last;
  assign name_failed    = head.failed && last;
  assign offset_after   = last ? head.off_last : head.off_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= dnle_pkg::SlotFirst;
    end else if (!empty && result_ready) begin
      idx <= last ? dnle_pkg::SlotFirst : idx + 1'b1;
    end
  end

endmodule

// ===== rtl/dns_name_label_encoder_unit.sv =====
// top level of the dns name label encoder
// depends on dnle_pkg, dnle_core, dnle_queue, dnle_out
//
// Channels: characters come in on char_valid/char_ready with name_char,
// final_char and new_buffer. Buffer writes leave on result_valid/result_ready,
// one beat per write slot. The buffer size register is written through
// cfg_valid/cfg_data; cfg_ready is always high.
// An ordinary character or a non-final dot gives one beat; a final character
// gives three beats (character, label length, terminator).
// A character's result group is registered in the queue before its first
// beat shows. Throughput: one character per cycle while results are taken
// every cycle and the queue has room; a final character holds the output
// for its three beats, absorbed by a four-group queue in front of the output.
// When the receiver stalls, the queue fills and char_ready drops once four
// result groups wait; beats hold steady until taken.
// Reset clears the write offset, the name state and the queue, and sets the
// buffer size to 512.
module dns_name_label_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  name_char,
  input  logic        final_char,
  input  logic        new_buffer,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        write_valid,
  output logic [15:0] write_position,
  output logic [7:0]  write_byte,
  output logic        run_end,
  output logic        name_done,
  output logic        name_failed,
  output logic [15:0] offset_after
);

  dnle_pkg::bundle_t bundle, head;
  logic              accept, full, empty, pop;

  assign cfg_ready  = 1'b1;
  assign char_ready = !full;
  assign accept     = char_valid && char_ready;

  dnle_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .name_char  (name_char),
    .final_char (final_char),
    .new_buffer (new_buffer),
    .bundle     (bundle)
  );

  dnle_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (bundle),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  dnle_out u_out (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .result_ready   (result_ready),
    .pop            (pop),
    .result_valid   (result_valid),
    .write_valid    (write_valid),
    .write_position (write_position),
    .write_byte     (write_byte),
    .run_end        (run_end),
    .name_done      (name_done),
    .name_failed    (name_failed),
    .offset_after   (offset_after)
  );

endmodule
